[rtl/core/fdc_pkg.sv]
// Package for the floppy controller command engine.
// Holds phase, operation and request codes and shared constants; no dependencies.
`timescale 1ns / 1ps
package fdc_pkg;
   localparam int MAX_SECTOR_BYTES_DEF = 4096;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_CMD  = 2'd1;
   localparam logic [1:0] PH_XFER = 2'd2;
   localparam logic [1:0] PH_RES  = 2'd3;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_STAT  = 2'd2;
   localparam logic [1:0] CMD_TICK  = 2'd3;

   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_READ      = 4'd1;
   localparam logic [3:0] OP_WRITE     = 4'd2;
   localparam logic [3:0] OP_WRITE_DEL = 4'd3;
   localparam logic [3:0] OP_READ_DEL  = 4'd4;
   localparam logic [3:0] OP_READ_DIAG = 4'd5;
   localparam logic [3:0] OP_READ_ID   = 4'd6;
   localparam logic [3:0] OP_FORMAT    = 4'd7;
   localparam logic [3:0] OP_SCAN_EQ   = 4'd8;
   localparam logic [3:0] OP_SCAN_LE   = 4'd9;
   localparam logic [3:0] OP_SCAN_HE   = 4'd10;
   localparam logic [3:0] OP_SEEK      = 4'd11;
   localparam logic [3:0] OP_RECAL     = 4'd12;
   localparam logic [3:0] OP_SENSE_INT = 4'd13;
   localparam logic [3:0] OP_SPECIFY   = 4'd14;
   localparam logic [3:0] OP_SENSE_DEV = 4'd15;

   localparam logic [2:0] RQ_NONE   = 3'd0;
   localparam logic [2:0] RQ_READ   = 3'd1;
   localparam logic [2:0] RQ_STORE  = 3'd2;
   localparam logic [2:0] RQ_COMMIT = 3'd3;
   localparam logic [2:0] RQ_FORMAT = 3'd4;

   localparam logic [1:0] CSR_SECTOR_BYTES = 2'd0;
   localparam logic [1:0] CSR_SPT          = 2'd1;
   localparam logic [1:0] CSR_RQM_DELAY    = 2'd2;

   localparam logic [7:0] MS_CB  = 8'h10;
   localparam logic [7:0] MS_DIO = 8'h40;
   localparam logic [7:0] MS_RQM = 8'h80;

   // Opcode decode of the first command byte.
   function automatic logic [3:0] decode_op(input logic [7:0] v);
      logic [3:0] op;
      op = OP_NONE;
      if ((v & 8'h1f) == 8'h06) op = OP_READ;
      if ((v & 8'h3f) == 8'h05) op = OP_WRITE;
      if ((v & 8'h3f) == 8'h09) op = OP_WRITE_DEL;
      if ((v & 8'h1f) == 8'h0c) op = OP_READ_DEL;
      if ((v & 8'hbf) == 8'h02) op = OP_READ_DIAG;
      if ((v & 8'hbf) == 8'h0a) op = OP_READ_ID;
      if ((v & 8'hbf) == 8'h0d) op = OP_FORMAT;
      if ((v & 8'h1f) == 8'h11) op = OP_SCAN_EQ;
      if ((v & 8'h1f) == 8'h19) op = OP_SCAN_LE;
      if ((v & 8'h1f) == 8'h1d) op = OP_SCAN_HE;
      if (v == 8'h0f) op = OP_SEEK;
      if (v == 8'h07) op = OP_RECAL;
      if (v == 8'h08) op = OP_SENSE_INT;
      if (v == 8'h03) op = OP_SPECIFY;
      if (v == 8'h04) op = OP_SENSE_DEV;
      return op;
   endfunction
endpackage

[rtl/core/fdc_core.sv]
// Command engine datapath and phase sequencer of the floppy controller.
// Depends on fdc_pkg. One accepted beat is decoded against the registered state in one step.
`timescale 1ns / 1ps
module fdc_core #(
   parameter int MAX_SECTOR_BYTES = fdc_pkg::MAX_SECTOR_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [1:0]  command,
   input  logic [7:0]  write_value,
   input  logic [3:0]  pres,
   input  logic [3:0]  enab,
   input  logic [3:0]  twos,
   input  logic [3:0]  rdo,
   input  logic [1:0]  read_outcome,
   input  logic        write_ok,
   input  logic [7:0]  byte_in,
   input  logic [12:0] sector_bytes,
   input  logic [7:0]  spt,
   input  logic [15:0] rqm_delay,
   output logic [79:0] result
);
   import fdc_pkg::*;

   localparam logic [12:0] MAX_SB = 13'(MAX_SECTOR_BYTES);

   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  op_ff, op_in;
   logic [9:0]  step_ff, step_in;
   logic [7:0]  opc_ff, opc_in;
   logic [1:0]  drv_ff, drv_in;
   logic        head_ff, head_in;
   logic [7:0]  cyl_ff, cyl_in, sec_ff, sec_in, size_ff, size_in, trk_ff, trk_in;
   logic [7:0]  fsec_ff, fsec_in, fill_ff, fill_in;
   logic [12:0] off_ff, off_in;
   logic [7:0]  st_ff [4];
   logic [7:0]  st_in [4];
   logic [7:0]  main_ff, main_in;
   logic        irq_ff, irq_in;
   logic [15:0] tmr_ff, tmr_in;

   logic [7:0]  rd;
   logic [2:0]  req;
   logic [11:0] o_off;
   logic [7:0]  o_bout;
   logic [15:0] o_block;
   logic [12:0] size;
   logic [9:0]  s_cur;
   logic [9:0]  target;
   logic [15:0] prod;
   logic [8:0]  tsides;
   logic [3:0]  dbit;
   logic [3:0]  op_dec;

   assign size = (sector_bytes > MAX_SB) ? MAX_SB : sector_bytes;

   always_comb begin
      phase_in = phase_ff; op_in = op_ff; step_in = step_ff; opc_in = opc_ff;
      drv_in = drv_ff; head_in = head_ff; cyl_in = cyl_ff; sec_in = sec_ff;
      size_in = size_ff; trk_in = trk_ff; fsec_in = fsec_ff; fill_in = fill_ff;
      off_in = off_ff; main_in = main_ff; irq_in = irq_ff; tmr_in = tmr_ff;
      for (int i = 0; i < 4; i++) st_in[i] = st_ff[i];
      rd = 8'hff; req = RQ_NONE; o_off = '0; o_bout = '0; o_block = '0;
      s_cur = step_ff;
      dbit = 4'b0001 << write_value[1:0];
      op_dec = decode_op(write_value);
      tsides = {1'b0, trk_ff} << twos[drv_ff];
      prod = 16'(spt * (16'(tsides) + 16'(write_value)));
      target = 10'({fsec_ff, 2'b00} - 10'd2);

      case (command)
         CMD_WRITE: begin
            case (phase_ff)
               PH_IDLE: begin
                  op_in = op_dec; opc_in = write_value; phase_in = PH_CMD;
                  step_in = 10'd1; main_in = main_ff | MS_CB;
                  case (op_dec)
                     OP_READ, OP_WRITE, OP_FORMAT: begin
                        st_in[0] = st_ff[0] & ~8'hc0;
                        st_in[1] = st_ff[1] & ~8'h06;
                        st_in[2] = st_ff[2] & ~8'h20;
                     end
                     OP_RECAL: st_in[0] = st_ff[0] & ~8'h20;
                     OP_SENSE_INT: begin
                        main_in = main_ff | MS_CB | MS_DIO;
                        phase_in = PH_RES; step_in = '0; irq_in = 1'b1;
                     end
                     OP_SEEK, OP_SPECIFY, OP_SENSE_DEV: ;
                     default: begin
                        main_in = main_ff & ~MS_CB; phase_in = PH_IDLE; irq_in = 1'b1;
                     end
                  endcase
               end
               PH_CMD: begin
                  step_in = step_ff + 10'd1;
                  // Drive selection refresh, shared by the first parameter byte.
                  if (s_cur == 10'd1 && (op_ff == OP_READ || op_ff == OP_WRITE ||
                      op_ff == OP_FORMAT || op_ff == OP_SEEK || op_ff == OP_RECAL ||
                      op_ff == OP_SENSE_DEV)) begin
                     drv_in = write_value[1:0];
                     if (op_ff != OP_RECAL) head_in = write_value[2];
                     st_in[0] = (st_ff[0] & ~8'hc3) | {~enab[write_value[1:0]] ? 1'b1 : 1'b0,
                        5'b0, write_value[1:0]} | {7'b0, (pres & dbit) == 4'b0};
                     st_in[3] = {1'b0, (rdo & dbit) != 4'b0, (pres & dbit) != 4'b0,
                        trk_ff == 8'd0 && op_ff != OP_RECAL || op_ff == OP_RECAL &&
                        trk_ff == 8'd0, (twos & dbit) != 4'b0, 1'b0, write_value[1:0]};
                  end
                  case (op_ff)
                     OP_READ, OP_WRITE: begin
                        if (s_cur == 10'd2) cyl_in = write_value;
                        else if (s_cur == 10'd4) sec_in = write_value;
                        else if (s_cur == 10'd5) begin
                           size_in = write_value;
                           off_in = (write_value == 8'd1 && opc_ff[7:6] == 2'b01) ?
                              13'd0 : size;
                        end else if (s_cur == 10'd8) begin
                           if (op_ff == OP_READ) begin
                              req = RQ_READ;
                              if (read_outcome == 2'd1) begin
                                 st_in[0] = st_ff[0] | 8'h40; st_in[1] = st_ff[1] | 8'h04;
                              end
                              if (read_outcome == 2'd2) begin
                                 st_in[0] = st_ff[0] | 8'h40; st_in[1] = st_ff[1] | 8'h20;
                                 st_in[2] = st_ff[2] | 8'h20;
                              end
                              main_in = main_ff | MS_DIO;
                           end else main_in = main_ff & ~MS_DIO;
                           phase_in = PH_XFER; step_in = '0; irq_in = 1'b1;
                        end
                     end
                     OP_FORMAT: begin
                        if (s_cur == 10'd2) size_in = write_value;
                        else if (s_cur == 10'd3) begin
                           fsec_in = write_value; sec_in = write_value;
                        end else if (s_cur == 10'd5) begin
                           fill_in = write_value; off_in = '0;
                           main_in = main_ff & ~MS_DIO;
                           phase_in = PH_XFER; step_in = '0; irq_in = 1'b1;
                        end
                     end
                     OP_SEEK: if (s_cur == 10'd2) begin
                        trk_in = write_value; st_in[0] = st_ff[0] | 8'h20;
                        main_in = main_ff & ~MS_CB; phase_in = PH_IDLE; irq_in = 1'b1;
                     end
                     OP_RECAL: if (s_cur == 10'd1) begin
                        trk_in = '0; st_in[0] = st_in[0] | 8'h20;
                        main_in = main_ff & ~MS_CB; phase_in = PH_IDLE; irq_in = 1'b1;
                     end
                     OP_SPECIFY: if (s_cur == 10'd2) begin
                        main_in = main_ff & ~MS_CB; phase_in = PH_IDLE; irq_in = 1'b1;
                     end
                     OP_SENSE_DEV: if (s_cur == 10'd1) begin
                        main_in = main_ff | MS_DIO; phase_in = PH_RES;
                        step_in = '0; irq_in = 1'b1;
                     end
                     default: ;
                  endcase
               end
               PH_XFER: begin
                  tmr_in = '0;
                  main_in = main_ff & ~MS_RQM;
                  if (op_ff == OP_WRITE) begin
                     if (off_ff < size) begin
                        o_off = off_ff[11:0]; o_bout = write_value; req = RQ_STORE;
                        off_in = off_ff + 13'd1;
                        if (off_in == size) begin
                           req = RQ_COMMIT;
                           if (!write_ok) st_in[1] = st_ff[1] | 8'h02;
                           phase_in = PH_RES; step_in = '0;
                           main_in = (main_ff & ~MS_RQM) | MS_DIO;
                        end
                     end
                  end else if (op_ff == OP_FORMAT) begin
                     case (step_ff[1:0])
                        2'd0: trk_in = write_value;
                        2'd1: begin
                           req = RQ_FORMAT; o_bout = fill_ff;
                           o_block = 16'(16'(sec_ff) - 16'd1 + prod);
                           if (!write_ok) st_in[1] = st_ff[1] | 8'h02;
                        end
                        2'd2: sec_in = write_value;
                        default: ;
                     endcase
                     step_in = step_ff + 10'd1;
                     if (step_in == target) begin
                        phase_in = PH_RES; step_in = '0;
                        main_in = (main_ff & ~MS_RQM) | MS_DIO;
                     end
                  end
               end
               default: ;
            endcase
         end
         CMD_READ: begin
            irq_in = 1'b0;
            if (phase_ff == PH_XFER) begin
               tmr_in = '0; main_in = main_ff & ~MS_RQM;
               if (op_ff == OP_READ && off_ff < size) begin
                  o_off = off_ff[11:0]; off_in = off_ff + 13'd1; rd = byte_in;
                  if (off_in == size) begin
                     phase_in = PH_RES; step_in = '0; irq_in = 1'b1;
                  end
               end
            end else if (phase_ff == PH_RES) begin
               step_in = step_ff + 10'd1;
               case (op_ff)
                  OP_READ, OP_WRITE, OP_FORMAT: begin
                     case (s_cur)
                        10'd0: rd = st_ff[0];
                        10'd1: rd = st_ff[1];
                        10'd2: rd = st_ff[2];
                        10'd3: rd = cyl_ff;
                        10'd4: rd = {7'b0, head_ff};
                        10'd5: rd = sec_ff;
                        10'd6: begin
                           rd = size_ff; phase_in = PH_IDLE;
                           main_in = main_ff & ~(MS_CB | MS_DIO);
                        end
                        default: ;
                     endcase
                  end
                  OP_SENSE_INT: begin
                     if (s_cur == 10'd0) rd = st_ff[0];
                     if (s_cur == 10'd1) begin
                        rd = trk_ff; phase_in = PH_IDLE;
                        main_in = main_ff & ~(MS_CB | MS_DIO);
                     end
                  end
                  OP_SENSE_DEV: if (s_cur == 10'd0) begin
                     rd = st_ff[3]; phase_in = PH_IDLE;
                     main_in = main_ff & ~(MS_CB | MS_DIO);
                  end
                  default: ;
               endcase
            end
         end
         CMD_STAT: begin
            if (!main_ff[7] && tmr_ff > rqm_delay) main_in = main_ff | MS_RQM;
            rd = main_in;
         end
         default: if (tmr_ff != 16'hffff) tmr_in = tmr_ff + 16'd1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; op_ff <= OP_NONE; step_ff <= '0; opc_ff <= '0;
         drv_ff <= '0; head_ff <= 1'b0; cyl_ff <= '0; sec_ff <= '0; size_ff <= '0;
         trk_ff <= '0; fsec_ff <= '0; fill_ff <= '0; off_ff <= '0;
         for (int i = 0; i < 4; i++) st_ff[i] <= '0;
         main_ff <= 8'ha0; irq_ff <= 1'b0; tmr_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; op_ff <= op_in; step_ff <= step_in; opc_ff <= opc_in;
         drv_ff <= drv_in; head_ff <= head_in; cyl_ff <= cyl_in; sec_ff <= sec_in;
         size_ff <= size_in; trk_ff <= trk_in; fsec_ff <= fsec_in; fill_ff <= fill_in;
         off_ff <= off_in;
         for (int i = 0; i < 4; i++) st_ff[i] <= st_in[i];
         main_ff <= main_in; irq_ff <= irq_in; tmr_ff <= tmr_in;
      end
   end

   // Result beat fields, written from the top bits down to read_data at bit 0.
   assign result = {5'b0, o_block, o_bout, o_off, sec_in, trk_in, head_in, drv_in, req,
                    irq_in, main_in, rd};
endmodule

[rtl/core/floppy_controller_command_engine.sv]
// Top level of the floppy controller command engine.
// Depends on fdc_pkg and fdc_core.
`timescale 1ns / 1ps
// The host side of a floppy controller. Each req_ beat carries one bus access
// (data write, data read, status read) or a tick, together with the drive flags
// and the media answers for that access. Each accepted beat produces exactly
// one rsp_ beat with the read byte, the main status, the interrupt level and
// any disk request with its address and data.
// The beat is decoded against the registered phase state and the result
// lands in the output register on the accepting edge.
// Throughput is one beat per cycle while results are taken; req_tready follows
// the output register, so a new beat is taken while the last result is taken in the same edge.
// When the receiver stalls, the result holds and req_tready drops until it is taken.
// The csr_ channel writes sector_bytes (0), sectors_per_track (1) and
// rqm_delay_ticks (2); it is always ready and is meant to be used while idle.
// Synchronous reset puts the phase to idle, main status to 0xA0 and the
// registers to their defaults; the output register is emptied.
module floppy_controller_command_engine #(
   parameter int MAX_SECTOR_BYTES = fdc_pkg::MAX_SECTOR_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[1:0], write_value[9:2], drives_present[13:10], drives_enabled[17:14],
   // drives_two_sided[21:18], drives_read_only[25:22], disk_read_outcome[27:26],
   // disk_write_ok[28], disk_byte_in[36:29], zero fill to 40 bits
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], main_status[15:8], interrupt_flag[16], disk_request[19:17],
   // disk_drive[21:20], disk_head[22], disk_track[30:23], disk_sector[38:31],
   // disk_offset[50:39], disk_byte_out[58:51], format_block[74:59], zero fill to 80
   output logic [79:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import fdc_pkg::*;

   logic        accept;
   logic [79:0] res;
   logic [12:0] sb_ff;
   logic [7:0]  spt_ff;
   logic [15:0] dly_ff;
   logic        vld_ff;
   logic [79:0] dat_ff;

   assign req_tready = !vld_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   fdc_core #(.MAX_SECTOR_BYTES(MAX_SECTOR_BYTES)) u_core (
      .clock(clock), .reset(reset), .step(accept),
      .command(req_tdata[1:0]), .write_value(req_tdata[9:2]),
      .pres(req_tdata[13:10]), .enab(req_tdata[17:14]),
      .twos(req_tdata[21:18]), .rdo(req_tdata[25:22]),
      .read_outcome(req_tdata[27:26]), .write_ok(req_tdata[28]),
      .byte_in(req_tdata[36:29]),
      .sector_bytes(sb_ff), .spt(spt_ff), .rqm_delay(dly_ff),
      .result(res)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff <= 13'd512; spt_ff <= 8'd9; dly_ff <= 16'd60;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SECTOR_BYTES: sb_ff <= csr_data[12:0];
            CSR_SPT:          spt_ff <= csr_data[7:0];
            CSR_RQM_DELAY:    dly_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (accept) vld_ff <= 1'b1;
      else if (rsp_tready) vld_ff <= 1'b0;
      if (accept) dat_ff <= res;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = dat_ff;
endmodule

[rtl/core/fdc_checker.sv]
// Port-level checker for the floppy controller command engine, with its bind.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
module fdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed under stall");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted beat produced no result");
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready) && (!rsp_tvalid || rsp_tready) |=> !rsp_tvalid)
      else $error("result beat without an input beat");
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output not empty after reset");
endmodule

bind floppy_controller_command_engine fdc_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

[bench/tb_floppy_controller_command_engine.sv]
// Self-checking bench for floppy_controller_command_engine.
// A directed table, then random well-formed command sequences, checked beat by beat
// against a predictor of the controller. Depends on fdc_pkg and the RTL top.
`timescale 1ns / 1ps
module tb_floppy_controller_command_engine;
   import fdc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] val;
      logic [3:0] pres;
      logic [3:0] enab;
      logic [3:0] twos;
      logic [3:0] rdo;
      logic [1:0] outc;
      logic       wok;
      logic [7:0] bin;
      logic       fixed;   // typed-in read byte and main status follow
      logic [7:0] rd_fix;
      logic [7:0] ms_fix;
   } bus_access_type;

   typedef struct packed {
      logic [7:0]  rd;
      logic [7:0]  ms;
      logic        irq;
      logic [2:0]  rq;
      logic [1:0]  drv;
      logic        hd;
      logic [7:0]  trk;
      logic [7:0]  sec;
      logic [11:0] off;
      logic [7:0]  bout;
      logic [15:0] blk;
   } engine_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   floppy_controller_command_engine dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Host accesses still to be offered, and replies predicted but not yet seen.
   bus_access_type   access_q[$];
   engine_reply_type reply_q[$];
   int  errors = 0;
   int  beats_in = 0;
   int  beats_out = 0;
   int  disk_reqs = 0;
   bit  sending = 1'b0;
   bit  gaps_on = 1'b1;
   int  stall_left = 0;
   int  hold_request = 0;
   int  noise_pct = 15;

   // Predicted controller state.
   logic [12:0] cfg_sector_bytes;
   logic [7:0]  cfg_spt;
   logic [15:0] cfg_rqm_delay;
   logic [1:0]  phase;
   logic [3:0]  oper;
   logic [9:0]  steps;
   logic [7:0]  opcode;
   logic [1:0]  drive;
   logic        head;
   logic [7:0]  cyl, sect, size_code, track, fmt_sectors, fill_byte;
   logic [12:0] offset;
   logic [7:0]  st [4];
   logic [7:0]  msr;
   logic        irq_level;
   logic [15:0] rqm_age;

   task automatic reset_model();
      cfg_sector_bytes = 13'd512;
      cfg_spt = 8'd9;
      cfg_rqm_delay = 16'd60;
      phase = PH_IDLE;
      oper = OP_NONE;
      steps = '0;
      opcode = '0;
      drive = '0;
      head = 1'b0;
      {cyl, sect, size_code, track, fmt_sectors, fill_byte} = '0;
      offset = '0;
      for (int i = 0; i < 4; i++) st[i] = '0;
      msr = 8'hA0;
      irq_level = 1'b0;
      rqm_age = '0;
   endtask

   // The opcode table; the first match returns.
   function automatic logic [3:0] opcode_kind(input logic [7:0] v);
      if (v == 8'h04) return OP_SENSE_DEV;
      if (v == 8'h03) return OP_SPECIFY;
      if (v == 8'h08) return OP_SENSE_INT;
      if (v == 8'h07) return OP_RECAL;
      if (v == 8'h0f) return OP_SEEK;
      case (v[4:0])
         5'h1d: return OP_SCAN_HE;
         5'h19: return OP_SCAN_LE;
         5'h11: return OP_SCAN_EQ;
         default: ;
      endcase
      if ((v & 8'hbf) == 8'h0d) return OP_FORMAT;
      if ((v & 8'hbf) == 8'h0a) return OP_READ_ID;
      if ((v & 8'hbf) == 8'h02) return OP_READ_DIAG;
      if (v[4:0] == 5'h0c) return OP_READ_DEL;
      if (v[5:0] == 6'h09) return OP_WRITE_DEL;
      if (v[5:0] == 6'h05) return OP_WRITE;
      if (v[4:0] == 5'h06) return OP_READ;
      return OP_NONE;
   endfunction

   // Selecting a drive refreshes bits 7:6 and the unit bits of ST0, and all of ST3.
   task automatic pick_drive(input bus_access_type a, input bit take_head);
      logic [3:0] bitm;
      drive = a.val[1:0];
      if (take_head) head = a.val[2];
      bitm = 4'b1 << drive;
      st[0] = (st[0] & ~8'hC3) | {(a.enab & bitm) == 0, 5'b0, a.val[1:0]}
              | ((a.pres & bitm) == 0 ? 8'h01 : 8'h00);
      st[3] = {1'b0, (a.rdo & bitm) != 0, (a.pres & bitm) != 0, track == 0,
               (a.twos & bitm) != 0, 1'b0, a.val[1:0]};
   endtask

   task automatic finish_command();
      msr &= ~MS_CB;
      phase = PH_IDLE;
      irq_level = 1'b1;
   endtask

   task automatic predict_access(input bus_access_type a, output engine_reply_type r);
      int sz;
      logic [9:0] s;
      int sides;
      logic [3:0] bitm;
      r = '0;
      r.rd = 8'hff;
      sz = (cfg_sector_bytes > 13'd4096) ? 4096 : cfg_sector_bytes;
      case (a.cmd)
         CMD_WRITE: begin
            if (phase == PH_IDLE) begin
               oper = opcode_kind(a.val);
               opcode = a.val;
               phase = PH_CMD;
               steps = 10'd1;
               msr |= MS_CB;
               case (oper)
                  OP_READ, OP_WRITE, OP_FORMAT: begin
                     st[0] &= ~8'hC0;
                     st[1] &= ~8'h06;
                     st[2] &= ~8'h20;
                  end
                  OP_RECAL: st[0] &= ~8'h20;
                  OP_SENSE_INT: begin
                     msr |= MS_DIO;
                     phase = PH_RES;
                     steps = '0;
                     irq_level = 1'b1;
                  end
                  OP_SEEK, OP_SPECIFY, OP_SENSE_DEV: ;
                  default: finish_command();
               endcase
            end else if (phase == PH_CMD) begin
               s = steps;
               steps = steps + 10'd1;
               case (oper)
                  OP_READ, OP_WRITE: begin
                     if (s == 1) pick_drive(a, 1'b1);
                     else if (s == 2) cyl = a.val;
                     else if (s == 4) sect = a.val;
                     else if (s == 5) begin
                        size_code = a.val;
                        offset = (a.val == 8'd1 && opcode[7:6] == 2'b01) ? '0 : 13'(sz);
                     end else if (s == 8) begin
                        if (oper == OP_READ) begin
                           r.rq = RQ_READ;
                           if (a.outc == 2'd1) begin
                              st[0] |= 8'h40;
                              st[1] |= 8'h04;
                           end
                           if (a.outc == 2'd2) begin
                              st[0] |= 8'h40;
                              st[1] |= 8'h20;
                              st[2] |= 8'h20;
                           end
                           msr |= MS_DIO;
                        end else begin
                           msr &= ~MS_DIO;
                        end
                        phase = PH_XFER;
                        steps = '0;
                        irq_level = 1'b1;
                     end
                  end
                  OP_FORMAT: begin
                     if (s == 1) pick_drive(a, 1'b1);
                     else if (s == 2) size_code = a.val;
                     else if (s == 3) begin
                        fmt_sectors = a.val;
                        sect = a.val;
                     end else if (s == 5) begin
                        fill_byte = a.val;
                        offset = '0;
                        msr &= ~MS_DIO;
                        phase = PH_XFER;
                        steps = '0;
                        irq_level = 1'b1;
                     end
                  end
                  OP_SEEK: begin
                     if (s == 1) pick_drive(a, 1'b1);
                     else if (s == 2) begin
                        track = a.val;
                        st[0] |= 8'h20;
                        finish_command();
                     end
                  end
                  OP_RECAL: begin
                     if (s == 1) begin
                        pick_drive(a, 1'b0);
                        track = '0;
                        st[0] |= 8'h20;
                        finish_command();
                     end
                  end
                  OP_SPECIFY: if (s == 2) finish_command();
                  OP_SENSE_DEV: begin
                     if (s == 1) begin
                        pick_drive(a, 1'b1);
                        msr |= MS_DIO;
                        phase = PH_RES;
                        steps = '0;
                        irq_level = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end else if (phase == PH_XFER) begin
               if (oper == OP_WRITE) begin
                  if (offset < sz) begin
                     r.off = offset[11:0];
                     r.bout = a.val;
                     r.rq = RQ_STORE;
                     offset = offset + 13'd1;
                     if (offset == sz) begin
                        r.rq = RQ_COMMIT;
                        if (!a.wok) st[1] |= 8'h02;
                        phase = PH_RES;
                        steps = '0;
                        msr |= MS_DIO;
                     end
                  end
               end else if (oper == OP_FORMAT) begin
                  // Four bytes per sector ID: track, head, sector, size.
                  case (steps[1:0])
                     2'd0: track = a.val;
                     2'd1: begin
                        bitm = 4'b1 << drive;
                        sides = ((a.twos & bitm) != 0) ? 2 : 1;
                        r.rq = RQ_FORMAT;
                        r.bout = fill_byte;
                        r.blk = 16'(int'(sect) - 1 +
                                    int'(cfg_spt) * (int'(track) * sides + int'(a.val)));
                        if (!a.wok) st[1] |= 8'h02;
                     end
                     2'd2: sect = a.val;
                     default: ;
                  endcase
                  steps = steps + 10'd1;
                  if (steps == 10'(4 * int'(fmt_sectors) - 2)) begin
                     phase = PH_RES;
                     steps = '0;
                     msr |= MS_DIO;
                  end
               end
               rqm_age = '0;
               msr &= ~MS_RQM;
            end
         end
         CMD_READ: begin
            irq_level = 1'b0;
            if (phase == PH_XFER) begin
               if (oper == OP_READ && offset < sz) begin
                  r.off = offset[11:0];
                  offset = offset + 13'd1;
                  if (offset == sz) begin
                     phase = PH_RES;
                     steps = '0;
                     irq_level = 1'b1;
                  end
                  r.rd = a.bin;
               end
               rqm_age = '0;
               msr &= ~MS_RQM;
            end else if (phase == PH_RES) begin
               s = steps;
               steps = steps + 10'd1;
               case (oper)
                  OP_READ, OP_WRITE, OP_FORMAT: begin
                     case (s)
                        10'd0: r.rd = st[0];
                        10'd1: r.rd = st[1];
                        10'd2: r.rd = st[2];
                        10'd3: r.rd = cyl;
                        10'd4: r.rd = {7'b0, head};
                        10'd5: r.rd = sect;
                        10'd6: begin
                           phase = PH_IDLE;
                           msr &= ~(MS_CB | MS_DIO);
                           r.rd = size_code;
                        end
                        default: ;
                     endcase
                  end
                  OP_SENSE_INT: begin
                     if (s == 0) r.rd = st[0];
                     else if (s == 1) begin
                        phase = PH_IDLE;
                        msr &= ~(MS_CB | MS_DIO);
                        r.rd = track;
                     end
                  end
                  OP_SENSE_DEV: begin
                     if (s == 0) begin
                        phase = PH_IDLE;
                        msr &= ~(MS_CB | MS_DIO);
                        r.rd = st[3];
                     end
                  end
                  default: ;
               endcase
            end
         end
         CMD_STAT: begin
            if ((msr & MS_RQM) == 0 && rqm_age > cfg_rqm_delay) msr |= MS_RQM;
            r.rd = msr;
         end
         default: if (rqm_age != 16'hffff) rqm_age = rqm_age + 16'd1;
      endcase
      r.ms = msr;
      r.irq = irq_level;
      r.drv = drive;
      r.hd = head;
      r.trk = track;
      r.sec = sect;
      if (a.fixed) begin
         r.rd = a.rd_fix;
         r.ms = a.ms_fix;
      end
   endtask

   // Sender: one gap per beat, then hold tvalid until the engine takes it.
   initial begin
      int gap;
      bus_access_type a;
      engine_reply_type r;
      @(negedge clock);
      forever begin
         if (access_q.size() == 0) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end else begin
            a = access_q.pop_front();
            sending = 1'b1;
            gap = gaps_on ? $urandom_range(0, 14) : 0;
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            req_tvalid <= 1'b1;
            req_tdata <= {3'b0, a.bin, a.wok, a.outc, a.rdo, a.twos, a.enab, a.pres,
                          a.val, a.cmd};
            do @(posedge clock); while (!req_tready);
            predict_access(a, r);
            reply_q.push_back(r);
            beats_in++;
            sending = 1'b0;
            @(negedge clock);
         end
      end
   end

   // Receiver: a random stall after every beat, plus a long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   // Checker: every reply beat against the oldest prediction.
   always @(posedge clock) begin
      engine_reply_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         stall_left = gaps_on ? $urandom_range(0, 14) : 0;
         beats_out++;
         if (reply_q.size() == 0) begin
            $error("reply beat with nothing expected");
            errors++;
         end else begin
            e = reply_q.pop_front();
            if (e.rq != RQ_NONE) disk_reqs++;
            compare_field("read_data", 16'(e.rd), 16'(rsp_tdata[7:0]));
            compare_field("main_status", 16'(e.ms), 16'(rsp_tdata[15:8]));
            compare_field("interrupt_flag", 16'(e.irq), 16'(rsp_tdata[16]));
            compare_field("disk_request", 16'(e.rq), 16'(rsp_tdata[19:17]));
            compare_field("disk_drive", 16'(e.drv), 16'(rsp_tdata[21:20]));
            compare_field("disk_head", 16'(e.hd), 16'(rsp_tdata[22]));
            compare_field("disk_track", 16'(e.trk), 16'(rsp_tdata[30:23]));
            compare_field("disk_sector", 16'(e.sec), 16'(rsp_tdata[38:31]));
            compare_field("disk_offset", 16'(e.off), 16'(rsp_tdata[50:39]));
            compare_field("disk_byte_out", 16'(e.bout), 16'(rsp_tdata[58:51]));
            compare_field("format_block", e.blk, rsp_tdata[74:59]);
         end
      end
   end

   // Watchdog on cycles in which no channel moves a beat.
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Queue one host access with random drive flags and media answers; now and then
   // a tick or a status poll slips in ahead of it.
   task automatic put(input logic [1:0] cmd, input logic [7:0] v);
      bus_access_type a;
      if ($urandom_range(0, 99) < noise_pct) begin
         a = '0;
         a.cmd = $urandom_range(0, 1) ? CMD_TICK : CMD_STAT;
         access_q.push_back(a);
      end
      a.cmd = cmd;
      a.val = v;
      a.pres = $urandom_range(0, 15);
      a.enab = $urandom_range(0, 15);
      a.twos = $urandom_range(0, 15);
      a.rdo = $urandom_range(0, 15);
      a.outc = $urandom_range(0, 3);
      a.wok = $urandom_range(0, 3) != 0;
      a.bin = $urandom_range(0, 255);
      a.fixed = 1'b0;
      a.rd_fix = '0;
      a.ms_fix = '0;
      access_q.push_back(a);
   endtask

   task automatic wait_idle();
      while (access_q.size() != 0 || sending || reply_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] sb, input logic [15:0] spt,
                             input logic [15:0] dly);
      logic [15:0] vals [3];
      vals = '{sb, spt, dly};
      for (int i = 0; i < 3; i++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= 2'(i);
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (2'(i))
            CSR_SECTOR_BYTES: cfg_sector_bytes = vals[i][12:0];
            CSR_SPT: cfg_spt = vals[i][7:0];
            default: cfg_rqm_delay = vals[i];
         endcase
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int bytes_now();
      return (cfg_sector_bytes > 13'd4096) ? 4096 : int'(cfg_sector_bytes);
   endfunction

   task automatic result_bytes(input int n);
      for (int i = 0; i < n; i++) put(CMD_READ, 8'h00);
   endtask

   // One data command: opcode, eight parameter bytes with size code one, the data
   // beats with an occasional wrong-direction access, then the seven result bytes.
   task automatic data_command(input bit is_read);
      int n;
      n = bytes_now();
      put(CMD_WRITE, is_read ? (8'h46 | 8'($urandom_range(0, 1)) << 5) : 8'h45);
      put(CMD_WRITE, $urandom_range(0, 255));
      put(CMD_WRITE, $urandom_range(0, 255));
      put(CMD_WRITE, $urandom_range(0, 255));
      put(CMD_WRITE, $urandom_range(0, 255));
      put(CMD_WRITE, 8'h01);
      put(CMD_WRITE, $urandom_range(0, 255));
      put(CMD_WRITE, $urandom_range(0, 255));
      put(CMD_WRITE, $urandom_range(0, 255));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) put(is_read ? CMD_WRITE : CMD_READ, $urandom_range(0, 255));
         put(is_read ? CMD_READ : CMD_WRITE, $urandom_range(0, 255));
      end
      result_bytes(7);
   endtask

   task automatic format_track(input logic [7:0] count);
      int n;
      put(CMD_WRITE, $urandom_range(0, 1) ? 8'h4d : 8'h0d);
      put(CMD_WRITE, $urandom_range(0, 255));
      put(CMD_WRITE, $urandom_range(0, 255));
      put(CMD_WRITE, count);
      put(CMD_WRITE, $urandom_range(0, 255));
      put(CMD_WRITE, $urandom_range(0, 255));
      n = (4 * int'(count) - 2) & 1023;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) put(CMD_READ, 8'h00);
         put(CMD_WRITE, $urandom_range(0, 255));
      end
      result_bytes(7);
   endtask

   task automatic random_command();
      logic [7:0] v;
      case ($urandom_range(0, 11))
         0, 1: data_command(1'b1);
         2, 3: data_command(1'b0);
         4: format_track($urandom_range(1, 4));
         5: begin
            put(CMD_WRITE, 8'h0f);
            put(CMD_WRITE, $urandom_range(0, 255));
            put(CMD_WRITE, $urandom_range(0, 255));
         end
         6: begin
            put(CMD_WRITE, 8'h07);
            put(CMD_WRITE, $urandom_range(0, 255));
         end
         7: begin
            put(CMD_WRITE, 8'h08);
            if ($urandom_range(0, 1)) put(CMD_WRITE, $urandom_range(0, 255));
            result_bytes(2);
         end
         8: begin
            put(CMD_WRITE, 8'h04);
            put(CMD_WRITE, $urandom_range(0, 255));
            result_bytes(1);
         end
         9: begin
            put(CMD_WRITE, 8'h03);
            put(CMD_WRITE, $urandom_range(0, 255));
            put(CMD_WRITE, $urandom_range(0, 255));
         end
         10: begin
            // An opcode that ends at once: unknown, or one that is not implemented.
            do v = $urandom_range(0, 255);
            while (!(opcode_kind(v) inside {OP_NONE, OP_WRITE_DEL, OP_READ_DEL,
                     OP_READ_DIAG, OP_READ_ID, OP_SCAN_EQ, OP_SCAN_LE, OP_SCAN_HE}));
            put(CMD_WRITE, v);
         end
         default: begin
            // A run of ticks, then a poll to see whether RQM has come back.
            repeat ($urandom_range(0, 10)) put(CMD_TICK, 8'h00);
            put(CMD_STAT, 8'h00);
            put(CMD_READ, 8'h00);
         end
      endcase
   endtask

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] val;
      logic       fixed;
      logic [7:0] rd;
      logic [7:0] ms;
   } table_row_type;

   // Directed start from reset: idle reads, an unknown opcode, sense interrupt
   // with a write ignored in result phase, recalibrate, seek to the top track,
   // specify, sense drive status, and RQM already set.
   localparam table_row_type DIRECTED [22] = '{
      '{CMD_STAT,  8'h00, 1'b1, 8'hA0, 8'hA0},
      '{CMD_READ,  8'h00, 1'b1, 8'hFF, 8'hA0},
      '{CMD_WRITE, 8'h00, 1'b1, 8'hFF, 8'hA0},
      '{CMD_READ,  8'h00, 1'b1, 8'hFF, 8'hA0},
      '{CMD_WRITE, 8'h08, 1'b1, 8'hFF, 8'hF0},
      '{CMD_WRITE, 8'h55, 1'b1, 8'hFF, 8'hF0},
      '{CMD_READ,  8'h00, 1'b1, 8'h00, 8'hF0},
      '{CMD_READ,  8'h00, 1'b1, 8'h00, 8'hA0},
      '{CMD_WRITE, 8'h07, 1'b0, 8'h00, 8'h00},
      '{CMD_WRITE, 8'h03, 1'b0, 8'h00, 8'h00},
      '{CMD_WRITE, 8'h0f, 1'b0, 8'h00, 8'h00},
      '{CMD_WRITE, 8'h07, 1'b0, 8'h00, 8'h00},
      '{CMD_WRITE, 8'hFF, 1'b0, 8'h00, 8'h00},
      '{CMD_WRITE, 8'h03, 1'b0, 8'h00, 8'h00},
      '{CMD_WRITE, 8'h00, 1'b0, 8'h00, 8'h00},
      '{CMD_WRITE, 8'hFF, 1'b0, 8'h00, 8'h00},
      '{CMD_WRITE, 8'h04, 1'b0, 8'h00, 8'h00},
      '{CMD_WRITE, 8'h06, 1'b0, 8'h00, 8'h00},
      '{CMD_READ,  8'h00, 1'b0, 8'h00, 8'h00},
      '{CMD_WRITE, 8'hFF, 1'b1, 8'hFF, 8'hA0},
      '{CMD_TICK,  8'h00, 1'b1, 8'hFF, 8'hA0},
      '{CMD_STAT,  8'h00, 1'b1, 8'hA0, 8'hA0}
   };

   // Settings walked by the random part: sector size, sectors per track, RQM delay.
   localparam logic [15:0] SETUPS [7][3] = '{
      '{16'd4,  16'd9,   16'd0},
      '{16'd1,  16'd255, 16'd3},
      '{16'd2,  16'd1,   16'd1},
      '{16'd8,  16'd17,  16'd5},
      '{16'd3,  16'd18,  16'd60},
      '{16'd5,  16'd36,  16'd2},
      '{16'd6,  16'd200, 16'd0}
   };

   initial begin
      int start;
      reset_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      noise_pct = 0;
      foreach (DIRECTED[i]) begin
         put(DIRECTED[i].cmd, DIRECTED[i].val);
         access_q[$].fixed = DIRECTED[i].fixed;
         access_q[$].rd_fix = DIRECTED[i].rd;
         access_q[$].ms_fix = DIRECTED[i].ms;
      end
      noise_pct = 15;

      for (int p = 0; p < 7; p++) begin
         wait_idle();
         set_config(SETUPS[p][0], SETUPS[p][1], SETUPS[p][2]);
         gaps_on = $urandom_range(0, 3) != 0;
         if (p == 1) begin
            // Let the sender run into a long receiver hold-off.
            @(posedge clock);
            hold_request = 300;
         end
         start = beats_in + access_q.size();
         while (beats_in + access_q.size() - start < 105) random_command();
      end

      // With the delay at its top, RQM stays clear after a data beat while ticks
      // follow; no gaps here.
      wait_idle();
      gaps_on = 1'b0;
      noise_pct = 0;
      set_config(16'd1, 16'd9, 16'd65535);
      data_command(1'b1);
      repeat (20) put(CMD_TICK, 8'h00);
      put(CMD_STAT, 8'h00);

      // Last, since it never leaves the transfer phase: an opcode with MT set is
      // not armed, and with zero-byte sectors no byte would move anyway.
      wait_idle();
      gaps_on = 1'b1;
      set_config(16'd0, 16'd9, 16'd0);
      put(CMD_WRITE, 8'hC6);
      repeat (8) put(CMD_WRITE, 8'h01);
      repeat (4) begin
         put(CMD_READ, 8'h00);
         put(CMD_WRITE, 8'h5A);
         put(CMD_STAT, 8'h00);
      end

      wait_idle();
      repeat (5) @(posedge clock);
      $display("Run covered %0d host beats and %0d reply beats, %0d with disk requests.",
               beats_in, beats_out, disk_reqs);
      $display("Sector sizes 0 to 8, all commands, stalls on both sides.");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
